/* hdl/bmpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants of the 24-bit BMP pixel stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  localparam int unsigned MaxDim  = 4096;
  localparam int unsigned DimW    = $clog2(MaxDim + 1);
  localparam int unsigned OrgW    = 12;
  localparam int unsigned CoordW  = 13;
  localparam int unsigned ColorW  = 24;
  localparam int unsigned AddW    = ((DimW > OrgW) ? DimW : OrgW) + 1;
  localparam int unsigned DataW   = 8;
  localparam int unsigned OutDataW = ((2 * CoordW + ColorW + 7) / 8) * 8;

  localparam int unsigned HdrLen    = 54;
  localparam int unsigned OffPos    = 10;
  localparam int unsigned WidthPos  = 18;
  localparam int unsigned HeightPos = 22;
  localparam int unsigned BppPos    = 28;
  localparam int unsigned CompPos   = 30;
  localparam int unsigned Bpp24     = 24;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgOriginX = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgOriginY = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_COMPLETE  = 2'd1,
    KIND_REJECT    = 2'd2,
    KIND_EARLY_EOF = 2'd3
  } kind_e;

  typedef struct packed {
    logic                pix_valid;
    logic [CoordW-1:0]   pixel_x;
    logic [CoordW-1:0]   pixel_y;
    logic [ColorW-1:0]   color;
    logic                st_valid;
    kind_e               st_kind;
  } res_entry_t;

endpackage

/* hdl/bmpd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_front
// Byte parser: captures and checks the header, skips to the pixel data,
// assembles BGR triples and pushes a record for each pixel or status.
// ----------------------------------------------------------------------------
module bmpd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic [bmpd_pkg::DataW-1:0]   byte_i,
  input  logic                         eof_i,
  input  logic [bmpd_pkg::OrgW-1:0]    origin_x_i,
  input  logic [bmpd_pkg::OrgW-1:0]    origin_y_i,
  output logic                         push_o,
  output bmpd_pkg::res_entry_t         entry_o
);
  import bmpd_pkg::*;

  phase_e            phase_q, phase_d, phase_step;
  logic [31:0]       pos_q, pos_d;
  logic [31:0]       offset_q, offset_d;
  logic [31:0]       width_q, width_d;
  logic [31:0]       height_q, height_d;
  logic [15:0]       bpp_q, bpp_d;
  logic [31:0]       comp_q, comp_d;
  logic [DimW-1:0]   ah_q, ah_d;
  logic [DimW-1:0]   row_q, row_d;
  logic [DimW-1:0]   col_q, col_d;
  logic [1:0]        bip_q, bip_d;
  logic [1:0]        pad_q, pad_d;
  logic [7:0]        blue_q, blue_d;
  logic [7:0]        green_q, green_d;

  logic [31:0]       pos_inc;
  logic [5:0]        hpos;
  logic [1:0]        slot;
  logic              hdr_end;
  logic [31:0]       ah32;
  logic              hdr_ok;
  logic [DimW-1:0]   col_inc;
  logic [DimW-1:0]   row_inc;
  logic              col_wrap;
  logic              row_last;
  logic [1:0]        pad_dec;
  logic              pix_fire;
  logic [DimW-1:0]   dy;
  logic [AddW-1:0]   sum_x;
  logic [AddW-1:0]   sum_y;

  assign pos_inc  = pos_q + 32'd1;
  assign hpos     = pos_q[5:0];
  assign hdr_end  = (pos_inc == 32'(HdrLen));
  assign ah32     = height_q[31] ? (32'd0 - height_q) : height_q;
  assign hdr_ok   = (bpp_q == 16'(Bpp24)) && (comp_q == 32'd0) && !width_q[31] &&
                    (width_q != 32'd0) && (width_q <= 32'(MaxDim)) &&
                    (height_q != 32'd0) && (ah32 <= 32'(MaxDim)) &&
                    (offset_q >= 32'(HdrLen));
  assign col_inc  = col_q + DimW'(1);
  assign row_inc  = row_q + DimW'(1);
  assign col_wrap = (col_inc >= width_q[DimW-1:0]);
  assign row_last = (row_inc >= ah_q);
  assign pad_dec  = pad_q - 2'd1;
  assign pix_fire = acc_i && (phase_q == PH_PIXEL) && (bip_q == 2'd2);
  assign dy       = height_q[31] ? row_q : (ah_q - DimW'(1) - row_q);
  assign sum_x    = AddW'(origin_x_i) + AddW'(col_q);
  assign sum_y    = AddW'(origin_y_i) + AddW'(dy);

  // Next phase.
  always_comb begin
    phase_step = phase_q;
    unique case (phase_q)
      PH_HEADER: begin
        if (hdr_end) begin
          if (!hdr_ok) begin
            phase_step = PH_DONE;
          end else if (offset_q > 32'(HdrLen)) begin
            phase_step = PH_SKIP;
          end else begin
            phase_step = PH_PIXEL;
          end
        end
      end
      PH_SKIP: begin
        if (pos_inc >= offset_q) begin
          phase_step = PH_PIXEL;
        end
      end
      PH_PIXEL: begin
        if (bip_q == 2'd2 && col_wrap) begin
          if (width_q[1:0] != 2'd0) begin
            phase_step = PH_PAD;
          end else begin
            phase_step = row_last ? PH_DONE : PH_PIXEL;
          end
        end
      end
      PH_PAD: begin
        if (pad_dec == 2'd0) begin
          phase_step = row_last ? PH_DONE : PH_PIXEL;
        end
      end
      default: phase_step = phase_q;
    endcase
    if (!acc_i) begin
      phase_d = phase_q;
    end else if (eof_i) begin
      phase_d = PH_HEADER;
    end else begin
      phase_d = phase_step;
    end
  end

  // Datapath and result record.
  always_comb begin
    pos_d    = pos_q;
    offset_d = offset_q;
    width_d  = width_q;
    height_d = height_q;
    bpp_d    = bpp_q;
    comp_d   = comp_q;
    ah_d     = ah_q;
    row_d    = row_q;
    col_d    = col_q;
    bip_d    = bip_q;
    pad_d    = pad_q;
    blue_d   = blue_q;
    green_d  = green_q;
    slot     = 2'd0;

    if (acc_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          pos_d = pos_inc;
          if (hpos >= 6'(OffPos) && hpos < 6'(OffPos + 4)) begin
            slot = 2'(hpos - 6'(OffPos));
            offset_d[{slot, 3'b000} +: 8] = byte_i;
          end else if (hpos >= 6'(WidthPos) && hpos < 6'(WidthPos + 4)) begin
            slot = 2'(hpos - 6'(WidthPos));
            width_d[{slot, 3'b000} +: 8] = byte_i;
          end else if (hpos >= 6'(HeightPos) && hpos < 6'(HeightPos + 4)) begin
            slot = 2'(hpos - 6'(HeightPos));
            height_d[{slot, 3'b000} +: 8] = byte_i;
          end else if (hpos >= 6'(BppPos) && hpos < 6'(BppPos + 2)) begin
            slot = 2'(hpos - 6'(BppPos));
            bpp_d[{slot[0], 3'b000} +: 8] = byte_i;
          end else if (hpos >= 6'(CompPos) && hpos < 6'(CompPos + 4)) begin
            slot = 2'(hpos - 6'(CompPos));
            comp_d[{slot, 3'b000} +: 8] = byte_i;
          end
          if (hdr_end) begin
            ah_d = ah32[DimW-1:0];
          end
        end
        PH_SKIP: begin
          pos_d = pos_inc;
        end
        PH_PIXEL: begin
          unique case (bip_q)
            2'd0: begin
              blue_d = byte_i;
              bip_d  = 2'd1;
            end
            2'd1: begin
              green_d = byte_i;
              bip_d   = 2'd2;
            end
            default: begin
              bip_d = 2'd0;
              col_d = col_inc;
              if (col_wrap) begin
                pad_d = width_q[1:0];
                if (width_q[1:0] == 2'd0) begin
                  col_d = '0;
                  row_d = row_inc;
                end
              end
            end
          endcase
        end
        PH_PAD: begin
          pad_d = pad_dec;
          if (pad_dec == 2'd0) begin
            col_d = '0;
            row_d = row_inc;
          end
        end
        default: ;
      endcase

      if (eof_i) begin
        pos_d    = '0;
        offset_d = '0;
        width_d  = '0;
        height_d = '0;
        bpp_d    = '0;
        comp_d   = '0;
        ah_d     = '0;
        row_d    = '0;
        col_d    = '0;
        bip_d    = '0;
        pad_d    = '0;
        blue_d   = '0;
        green_d  = '0;
      end
    end
  end

  always_comb begin
    entry_o.pix_valid = pix_fire;
    entry_o.pixel_x   = sum_x[CoordW-1:0];
    entry_o.pixel_y   = sum_y[CoordW-1:0];
    entry_o.color     = {byte_i, green_q, blue_q};
    entry_o.st_valid  = 1'b0;
    entry_o.st_kind   = KIND_EARLY_EOF;
    if (phase_q != PH_DONE && phase_step == PH_DONE) begin
      entry_o.st_valid = 1'b1;
      entry_o.st_kind  = (phase_q == PH_HEADER) ? KIND_REJECT : KIND_COMPLETE;
    end else if (eof_i && phase_step != PH_DONE) begin
      entry_o.st_valid = 1'b1;
      entry_o.st_kind  = KIND_EARLY_EOF;
    end
    entry_o.st_valid = entry_o.st_valid && acc_i;
  end

  assign push_o = entry_o.pix_valid || entry_o.st_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      offset_q <= '0;
      width_q  <= '0;
      height_q <= '0;
      bpp_q    <= '0;
      comp_q   <= '0;
      ah_q     <= '0;
      row_q    <= '0;
      col_q    <= '0;
      bip_q    <= '0;
      pad_q    <= '0;
      blue_q   <= '0;
      green_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      offset_q <= offset_d;
      width_q  <= width_d;
      height_q <= height_d;
      bpp_q    <= bpp_d;
      comp_q   <= comp_d;
      ah_q     <= ah_d;
      row_q    <= row_d;
      col_q    <= col_d;
      bip_q    <= bip_d;
      pad_q    <= pad_d;
      blue_q   <= blue_d;
      green_q  <= green_d;
    end
  end

endmodule

/* hdl/bmpd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_queue
// Small first-in first-out queue of result records between parser and
// output stage.
// ----------------------------------------------------------------------------
module bmpd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bmpd_pkg::res_entry_t  wdata_i,
  input  logic                  pop_i,
  output bmpd_pkg::res_entry_t  rdata_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import bmpd_pkg::*;

  res_entry_t        mem_q [QDepth];
  logic [QAddrW-1:0] wptr_q, wptr_d;
  logic [QAddrW-1:0] rptr_q, rptr_d;
  logic [QAddrW:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QAddrW + 1)'(QDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? wptr_q + QAddrW'(1) : wptr_q;
    rptr_d = do_pop ? rptr_q + QAddrW'(1) : rptr_q;
    cnt_d  = cnt_q + (QAddrW + 1)'(do_push) - (QAddrW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* hdl/bmpd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_back
// Output stage: splits each queued record into its pixel and status
// results and holds them in the output register until taken.
// ----------------------------------------------------------------------------
module bmpd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bmpd_pkg::res_entry_t            head_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bmpd_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic [1:0]                      m_axis_tuser
);
  import bmpd_pkg::*;

  localparam int unsigned PadW = OutDataW - 2 * CoordW - ColorW;

  logic                  vld_q, vld_d;
  logic                  pix_sent_q, pix_sent_d;
  logic [OutDataW-1:0]   data_q, data_d;
  kind_e                 kind_q, kind_d;
  logic                  load;
  logic                  send_pix;

  assign load     = !empty_i && (!vld_q || m_axis_tready);
  assign send_pix = head_i.pix_valid && !pix_sent_q;

  always_comb begin
    vld_d      = vld_q;
    pix_sent_d = pix_sent_q;
    data_d     = data_q;
    kind_d     = kind_q;
    pop_o      = 1'b0;
    if (m_axis_tready) begin
      vld_d = 1'b0;
    end
    if (load) begin
      vld_d = 1'b1;
      if (send_pix) begin
        kind_d = KIND_PIXEL;
        data_d = {{PadW{1'b0}}, head_i.color, head_i.pixel_y, head_i.pixel_x};
        if (head_i.st_valid) begin
          pix_sent_d = 1'b1;
        end else begin
          pop_o = 1'b1;
        end
      end else begin
        kind_d     = head_i.st_kind;
        data_d     = '0;
        pix_sent_d = 1'b0;
        pop_o      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= 1'b0;
      pix_sent_q <= 1'b0;
    end else begin
      vld_q      <= vld_d;
      pix_sent_q <= pix_sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    kind_q <= kind_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = kind_q;

endmodule

/* hdl/bmp24_pixel_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_pixel_stream_decoder
// Decodes a 24-bit uncompressed BMP byte stream into screen pixels.
// ----------------------------------------------------------------------------
// The file enters one byte per transaction on the slave channel, with tlast
// on its final byte. The header is checked on its 54th byte; a bad header
// gives one reject status. Every BGR triple of the pixel area gives one
// pixel result on the master channel: tuser holds the kind, tdata the
// screen column, screen row and RGB color. The byte that ends the last row
// adds a completion status; tlast before that adds an early-end status.
// tlast always rearms the decoder for the next file. The origin registers
// are written through the cfg channel, index 0 for the column and index 1
// for the row. The user must write them only while no file is in progress;
// the block itself leaves it unchecked. One byte is taken every cycle while
// the queue has room. A result is registered in the record queue, then in
// the output register. A byte that causes both a pixel and a status gives
// two results, which the four-entry record queue absorbs. When the receiver
// stalls, the queue fills and tready drops. Reset clears the parser, the
// queue and the output register, and puts both origins back to zero.
// ----------------------------------------------------------------------------
module bmp24_pixel_stream_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Slave tdata: data_byte [7:0]. tlast: end_of_file.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bmpd_pkg::DataW-1:0]      s_axis_tdata,
  input  logic                            s_axis_tlast,
  // Master tdata: pixel_x [12:0], pixel_y [25:13], color [49:26], zeros.
  // Master tuser: kind [1:0].
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bmpd_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic [1:0]                      m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bmpd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bmpd_pkg::OrgW-1:0]       cfg_data_i
);
  import bmpd_pkg::*;

  logic [OrgW-1:0] origin_x_q, origin_x_d;
  logic [OrgW-1:0] origin_y_q, origin_y_d;
  logic            acc;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;
  res_entry_t      entry;
  res_entry_t      head;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOriginX: origin_x_d = cfg_data_i;
        CfgOriginY: origin_y_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else begin
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
    end
  end

  bmpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .byte_i     (s_axis_tdata),
    .eof_i      (s_axis_tlast),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .push_o     (push),
    .entry_o    (entry)
  );

  bmpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (entry),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty),
    .full_o  (full)
  );

  bmpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* tb/sv/bmpd_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmpd_pixel_checker
// Predicts and checks the results of the 24-bit BMP pixel stream decoder.
// ----------------------------------------------------------------------------
// Follows every byte transaction and origin write of the decoder, rebuilds
// the header, skip, pixel and padding walk on its own, and queues the pixel
// and status results each byte must cause. Every result transaction is
// compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module bmpd_pixel_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [bmpd_pkg::DataW-1:0]    s_tdata_i,
  input  logic                          s_tlast_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [bmpd_pkg::OutDataW-1:0] m_tdata_i,
  input  logic [1:0]                    m_tuser_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bmpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bmpd_pkg::OrgW-1:0]     cfg_data_i,
  output int                            mismatches_o,
  output int                            outstanding_o,
  output int                            pixels_o,
  output int                            statuses_o
);

  import bmpd_pkg::*;

  typedef struct packed {
    kind_e             kind;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [ColorW-1:0] rgb;
  } screen_result_t;

  screen_result_t    due_results[$];
  logic [OrgW-1:0]   org_x;
  logic [OrgW-1:0]   org_y;
  phase_e            phase;
  logic [31:0]       byte_pos;
  logic [31:0]       data_off;
  logic [31:0]       img_w;
  logic [31:0]       img_h;
  logic [31:0]       comp_kind;
  logic [15:0]       bpp;
  logic [CoordW-1:0] row_idx;
  logic [CoordW-1:0] col_idx;
  logic [1:0]        pix_byte;
  logic [1:0]        pad_left;
  logic [7:0]        blue;
  logic [7:0]        green;
  int                mismatches = 0;
  int                pixels = 0;
  int                statuses = 0;

  function automatic logic [31:0] rows_total(input logic [31:0] h);
    return h[31] ? 32'd0 - h : h;
  endfunction

  task automatic clear_file();
    phase = PH_HEADER;
    byte_pos = '0;
    data_off = '0;
    img_w = '0;
    img_h = '0;
    comp_kind = '0;
    bpp = '0;
    row_idx = '0;
    col_idx = '0;
    pix_byte = '0;
    pad_left = '0;
    blue = '0;
    green = '0;
  endtask

  task automatic owe(input kind_e k, input logic [31:0] x, input logic [31:0] y,
                     input logic [ColorW-1:0] rgb);
    due_results.push_back('{kind: k, col: x[CoordW-1:0], row: y[CoordW-1:0], rgb: rgb});
  endtask

  function automatic logic end_row();
    col_idx = '0;
    row_idx = row_idx + 1'b1;
    if (32'(row_idx) >= rows_total(img_h)) begin
      phase = PH_DONE;
      return 1'b1;
    end
    phase = PH_PIXEL;
    return 1'b0;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic eof);
    logic [31:0] mag;
    logic [31:0] dy;
    mag = rows_total(img_h);
    case (phase)
      PH_HEADER: begin
        if (byte_pos >= OffPos && byte_pos < OffPos + 4)
          data_off[8*(byte_pos - OffPos) +: 8] = b;
        else if (byte_pos >= WidthPos && byte_pos < WidthPos + 4)
          img_w[8*(byte_pos - WidthPos) +: 8] = b;
        else if (byte_pos >= HeightPos && byte_pos < HeightPos + 4)
          img_h[8*(byte_pos - HeightPos) +: 8] = b;
        else if (byte_pos >= BppPos && byte_pos < BppPos + 2)
          bpp[8*(byte_pos - BppPos) +: 8] = b;
        else if (byte_pos >= CompPos && byte_pos < CompPos + 4)
          comp_kind[8*(byte_pos - CompPos) +: 8] = b;
        byte_pos = byte_pos + 1;
        if (byte_pos >= HdrLen) begin
          mag = rows_total(img_h);
          if (bpp != Bpp24 || comp_kind != 0 || img_w[31] || img_w == 0 ||
              img_w > MaxDim || img_h == 0 || mag > MaxDim || data_off < HdrLen) begin
            phase = PH_DONE;
            owe(KIND_REJECT, 0, 0, 0);
          end else if (data_off > HdrLen) begin
            phase = PH_SKIP;
          end else begin
            phase = PH_PIXEL;
          end
        end
      end
      PH_SKIP: begin
        byte_pos = byte_pos + 1;
        if (byte_pos >= data_off) phase = PH_PIXEL;
      end
      PH_PIXEL: begin
        if (pix_byte == 2'd0) begin
          blue = b;
          pix_byte = 2'd1;
        end else if (pix_byte == 2'd1) begin
          green = b;
          pix_byte = 2'd2;
        end else begin
          dy = img_h[31] ? 32'(row_idx) : mag - 1 - 32'(row_idx);
          pix_byte = 2'd0;
          owe(KIND_PIXEL, 32'(org_x) + 32'(col_idx), 32'(org_y) + dy, {b, green, blue});
          col_idx = col_idx + 1'b1;
          if (32'(col_idx) >= img_w) begin
            pad_left = img_w[1:0];
            if (pad_left != 2'd0) phase = PH_PAD;
            else if (end_row()) owe(KIND_COMPLETE, 0, 0, 0);
          end
        end
      end
      PH_PAD: begin
        pad_left = pad_left - 1'b1;
        if (pad_left == 2'd0 && end_row()) owe(KIND_COMPLETE, 0, 0, 0);
      end
      default: ;
    endcase
    if (eof) begin
      if (phase != PH_DONE) owe(KIND_EARLY_EOF, 0, 0, 0);
      clear_file();
    end
  endtask

  task automatic report(input string msg);
    if (mismatches < 50) $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    screen_result_t got;
    screen_result_t want;
    if (!rst_ni) begin
      org_x = '0;
      org_y = '0;
      clear_file();
      due_results.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = '{kind: kind_e'(m_tuser_i), col: m_tdata_i[CoordW-1:0],
                row: m_tdata_i[2*CoordW-1:CoordW], rgb: m_tdata_i[2*CoordW +: ColorW]};
        if (got.kind == KIND_PIXEL) pixels++;
        else statuses++;
        if (due_results.size() == 0) begin
          report($sformatf("result of kind %0d with nothing pending", got.kind));
        end else begin
          want = due_results.pop_front();
          if (got.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
          if (got.col !== want.col)
            report($sformatf("pixel_x %0d, expected %0d", got.col, want.col));
          if (got.row !== want.row)
            report($sformatf("pixel_y %0d, expected %0d", got.row, want.row));
          if (got.rgb !== want.rgb)
            report($sformatf("color %06h, expected %06h", got.rgb, want.rgb));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgOriginX) org_x = cfg_data_i;
        else if (cfg_index_i == CfgOriginY) org_y = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) decode_byte(s_tdata_i, s_tlast_i);
    end
    mismatches_o  <= mismatches;
    outstanding_o <= due_results.size();
    pixels_o      <= pixels;
    statuses_o    <= statuses;
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the 24-bit BMP pixel stream decoder.
// ----------------------------------------------------------------------------
// Streams a few directed BMP files with no idling: a pixel and a completion
// on the file's last byte, a cut right after a pixel, a cut header, a zero
// height, a one-byte file and the largest size at the far origin. Then it
// sends random files under three idle and stall mixes: mostly well-formed
// images, plus corrupted headers, truncated files and noise. New origins
// are written between the mixes. A checker beside the decoder predicts
// and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  import bmpd_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = CfgOriginX;
  logic [OrgW-1:0]     cfg_data = '0;

  int                  mismatches;
  int                  outstanding;
  int                  pixels;
  int                  statuses;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  bytes_sent = 0;
  int                  files_sent = 0;
  int                  idle_mix[4] = '{0, 59, 0, 19};
  int                  stall_mix[4] = '{0, 0, 59, 19};
  logic [7:0]          file_bytes[$];

  bmp24_pixel_stream_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  bmpd_pixel_checker pixel_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tlast_i     (s_axis_tlast),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .pixels_o      (pixels),
    .statuses_o    (statuses)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic push_byte(input logic [7:0] b, input logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eof;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Holds the byte stream until every owed result has come out, then lets
  // the pipeline run empty in case the last byte caused no result.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [OrgW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_origin(input logic [OrgW-1:0] x, input logic [OrgW-1:0] y);
    settle();
    write_reg(CfgOriginX, x);
    write_reg(CfgOriginY, y);
    cfg_valid <= 1'b0;
  endtask

  task automatic put_word(input int pos, input logic [31:0] val);
    for (int i = 0; i < 4; i++) file_bytes[pos + i] = val[8*i +: 8];
  endtask

  task automatic add_junk(input int n);
    repeat (n) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  task automatic begin_file(input logic [31:0] offset, input logic [31:0] width,
                            input logic [31:0] height, input logic [15:0] bits,
                            input logic [31:0] comp);
    file_bytes.delete();
    add_junk(HdrLen);
    put_word(OffPos, offset);
    put_word(WidthPos, width);
    put_word(HeightPos, height);
    file_bytes[BppPos]     = bits[7:0];
    file_bytes[BppPos + 1] = bits[15:8];
    put_word(CompPos, comp);
    if (offset > HdrLen && offset < HdrLen + 64) add_junk(offset - HdrLen);
  endtask

  task automatic add_rows(input int width, input int rows);
    add_junk(rows * (3 * width + width % 4));
  endtask

  // Sends the first cut bytes of the file (all of it when cut is zero),
  // with end of file on the last one sent.
  task automatic send_file(input int cut);
    int n;
    n = (cut > 0 && cut < file_bytes.size()) ? cut : file_bytes.size();
    for (int i = 0; i < n; i++) push_byte(file_bytes[i], i == n - 1);
    files_sent++;
  endtask

  task automatic random_file();
    int          pick;
    int          w;
    int          mag;
    int          extra;
    int          cut;
    logic [31:0] h;
    pick  = $urandom_range(9);
    w     = ($urandom_range(4) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
    mag   = $urandom_range(2, 1);
    h     = $urandom_range(1) ? -mag : mag;
    extra = $urandom_range(1) ? 0 : $urandom_range(6, 1);
    cut   = 0;
    begin_file(HdrLen + extra, w, h, Bpp24, 0);
    add_rows(w, mag);
    if (pick == 0) begin
      file_bytes.delete();
      add_junk($urandom_range(70, 1));
    end else if (pick == 1) begin
      case ($urandom_range(3))
        0: file_bytes[BppPos] = file_bytes[BppPos] ^ 8'($urandom_range(255, 1));
        1: file_bytes[CompPos + $urandom_range(3)] = 8'($urandom_range(255, 1));
        2: file_bytes[WidthPos + 3] = 8'($urandom_range(255, 1));
        default: put_word(OffPos, $urandom_range(HdrLen - 1));
      endcase
    end else if (pick < 4) begin
      cut = $urandom_range(file_bytes.size(), 1);
    end
    add_junk($urandom_range(3));
    send_file(cut);
  endtask

  initial begin : stimulus
    int start_bytes;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_origin(12'd0, 12'd0);

    // Directed files with no idling and no stalls.
    begin_file(HdrLen, 4, -1, Bpp24, 0);
    add_rows(4, 1);
    send_file(0);
    begin_file(HdrLen, 2, 2, Bpp24, 0);
    add_rows(2, 2);
    send_file(HdrLen + 3);
    begin_file(HdrLen, 5, 2, Bpp24, 0);
    send_file(10);
    begin_file(HdrLen, 5, 0, Bpp24, 0);
    send_file(HdrLen);
    file_bytes.delete();
    add_junk(1);
    send_file(0);

    // Largest image size with the origin at its far corner.
    set_origin(12'hFFF, 12'hFFF);
    begin_file(HdrLen, MaxDim, MaxDim, Bpp24, 0);
    add_junk(3);
    send_file(0);

    for (int p = 1; p < 4; p++) begin
      case (p)
        1: set_origin(12'hFFF, 12'd0);
        2: set_origin(12'd0, 12'hFFF);
        default: set_origin(12'($urandom), 12'($urandom));
      endcase
      send_idle_pct = idle_mix[p];
      stall_pct     = stall_mix[p];
      start_bytes   = bytes_sent;
      while (bytes_sent - start_bytes < 40) random_file();
    end

    settle();
    $display("Run covered %0d files in %0d byte transactions under four idle and stall mixes.",
             files_sent, bytes_sent);
    $display("Checked %0d pixels and %0d status results; %0d mismatches.",
             pixels, statuses, mismatches);
    if (mismatches == 0) begin
      $display("[bmp24_pixel_stream_decoder] OK");
    end else begin
      $display("[bmp24_pixel_stream_decoder] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("[bmp24_pixel_stream_decoder] ERROR");
    $finish;
  end

endmodule
